@@ rtl/cfs_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cfs_pkg - shared definitions for the complex frequency shifter
// Default sizes, register indexes, configuration bundle and the elaboration
// time function that builds the quarter-wave sine table.
// ============================================================================
package cfs_pkg;

   // Default sizes, handed down from the top level parameters
   localparam int SAMPLE_BITS_DEF     = 16;
   localparam int PHASE_BITS_DEF      = 32;
   localparam int TABLE_ADDR_BITS_DEF = 10;

   // Fixed widths of the register file
   localparam int STEP_BITS      = 32;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_RUN_ENABLE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_STEP = CSR_INDEX_BITS'(1);

   // Quadrant codes, top two phase bits
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   // pi/2 in Q62
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

   // Configuration bundle from the register file to the front end
   typedef struct packed {
      logic                 run_enable;
      logic [STEP_BITS-1:0] phase_step;
   } cfg_type;

   // floor(a * b / 2^62), operands below 2^63
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // Sine table entry k of a quarter wave with 2^tab_bits steps, scaled to
   // 2^(sample_bits-1); Taylor series in Q62, evaluated at elaboration only
   function automatic logic [63:0] sine_entry(input int k, input int tab_bits,
                                              input int sample_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      logic [63:0] one;
      logic [63:0] mask;
      int          sh;
      sh   = 62 - (sample_bits - 1);
      one  = 64'd1 << (sample_bits - 1);
      mask = (64'd1 << tab_bits) - 64'd1;
      x    = (HALF_PI_Q62 >> tab_bits) * 64'(k) +
             (((HALF_PI_Q62 & mask) * 64'(k)) >> tab_bits);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      // odd terms x^3 .. x^27, alternating sign
      term = mul_q62(term, x2) / 64'd6;   sum = sum - term;
      term = mul_q62(term, x2) / 64'd20;  sum = sum + term;
      term = mul_q62(term, x2) / 64'd42;  sum = sum - term;
      term = mul_q62(term, x2) / 64'd72;  sum = sum + term;
      term = mul_q62(term, x2) / 64'd110; sum = sum - term;
      term = mul_q62(term, x2) / 64'd156; sum = sum + term;
      term = mul_q62(term, x2) / 64'd210; sum = sum - term;
      term = mul_q62(term, x2) / 64'd272; sum = sum + term;
      term = mul_q62(term, x2) / 64'd342; sum = sum - term;
      term = mul_q62(term, x2) / 64'd420; sum = sum + term;
      term = mul_q62(term, x2) / 64'd506; sum = sum - term;
      term = mul_q62(term, x2) / 64'd600; sum = sum + term;
      term = mul_q62(term, x2) / 64'd702; sum = sum - term;
      v = (sum + (64'd1 << (sh - 1))) >> sh;
      if (v > one) begin
         v = one;
      end
      // end points are exact
      if (k == 0) begin
         v = 64'd0;
      end
      if (k == (1 << tab_bits)) begin
         v = one;
      end
      return v;
   endfunction

endpackage

@@ rtl/cfs_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cfs_front - sample intake and phase accumulator
// Accepts samples, applies the phase clear, attaches quadrant, table index
// and the run flag, advances the phase and pushes the work into the queue.
// ============================================================================
module cfs_front
   import cfs_pkg::*;
#(
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
   localparam int ENTRY_BITS     = 3 + TABLE_ADDR_BITS + 2 * SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_i,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_q,
   input  logic                          req_clear_phase,
   input  logic                          queue_full,
   output logic                          push_valid,
   output logic [ENTRY_BITS-1:0]         push_data
);

   localparam int EXT_BITS = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;

   logic                   accept;
   logic [PHASE_BITS-1:0]  phase_ff;
   logic [PHASE_BITS-1:0]  phase_in;
   logic [PHASE_BITS-1:0]  phase_cur;
   logic [PHASE_BITS-1:0]  step_scaled;
   logic signed [EXT_BITS-1:0] step_ext;

   // Step scaled to the accumulator width
   assign step_ext = EXT_BITS'($signed(cfg.phase_step));

   generate
      if (PHASE_BITS >= STEP_BITS) begin : g_step_up
         assign step_scaled = PHASE_BITS'(step_ext <<< (PHASE_BITS - STEP_BITS));
      end else begin : g_step_down
         assign step_scaled = PHASE_BITS'(step_ext >>> (STEP_BITS - PHASE_BITS));
      end
   endgenerate

   // Handshake: stall only while the queue is full
   assign req_stall  = queue_full;
   assign accept     = req_valid & ~queue_full;
   assign push_valid = accept;

   // Clear takes effect before the sample uses the phase
   assign phase_cur = req_clear_phase ? '0 : phase_ff;

   // Queue entry: run, quadrant, table index, I, Q
   assign push_data = {cfg.run_enable,
                       phase_cur[PHASE_BITS-1 -: 2],
                       phase_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS],
                       req_sample_i,
                       req_sample_q};

   // Phase holds while not running
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         phase_in = cfg.run_enable ? (phase_cur + step_scaled) : phase_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

@@ rtl/cfs_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cfs_queue - short queue between front and back
// Small register FIFO so that intake and datapath stall independently.
// ============================================================================
module cfs_queue
   import cfs_pkg::*;
#(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = QUEUE_DEPTH,
   localparam int PTR_BITS = $clog2(DEPTH),
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   assign full  = (count_ff == CNT_BITS'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Pointers wrap naturally, depth is a power of two
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + PTR_BITS'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + PTR_BITS'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/cfs_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cfs_back - rotation datapath
// Table lookup, complex multiply, rounding and saturation, with the result
// register. All stages advance together whenever the result can move.
// ============================================================================
module cfs_back
   import cfs_pkg::*;
#(
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
   localparam int ENTRY_BITS     = 3 + TABLE_ADDR_BITS + 2 * SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_empty,
   input  logic [ENTRY_BITS-1:0]         queue_head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_i,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_q
);

   localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;
   localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS + 1;
   localparam int TRIG_BITS = SAMPLE_BITS + 1;
   localparam int PROD_BITS = 2 * SAMPLE_BITS + 1;
   localparam int ACC_BITS  = 2 * SAMPLE_BITS + 2;
   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS =
      ACC_BITS'(64'd1 << (SAMPLE_BITS - 2));
   localparam logic signed [ACC_BITS-1:0] SAT_MAX =
      ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);

   // Quarter-wave sine table, constant
   logic [SAMPLE_BITS-1:0] rom_tab [TABLE_SIZE + 1];

   generate
      for (genvar k = 0; k <= TABLE_SIZE; k++) begin : g_rom
         localparam logic [SAMPLE_BITS-1:0] ROM_VAL =
            SAMPLE_BITS'(sine_entry(k, TABLE_ADDR_BITS, SAMPLE_BITS));
         assign rom_tab[k] = ROM_VAL;
      end
   endgenerate

   // Saturate a rounded sum to the sample range
   function automatic logic [SAMPLE_BITS-1:0] saturate(input logic signed [ACC_BITS-1:0] v);
      if (v > SAT_MAX) begin
         return SAMPLE_BITS'(SAT_MAX);
      end else if (v < SAT_MIN) begin
         return SAMPLE_BITS'(SAT_MIN);
      end
      return SAMPLE_BITS'(v);
   endfunction

   logic stage_en;

   // Queue head fields
   logic                          h_run;
   logic [1:0]                    h_quad;
   logic [TABLE_ADDR_BITS-1:0]    h_d;
   logic signed [SAMPLE_BITS-1:0] h_i;
   logic signed [SAMPLE_BITS-1:0] h_q;
   logic [ROM_ADDR_BITS-1:0]      addr_lo;
   logic [ROM_ADDR_BITS-1:0]      addr_hi;

   // Stage 0: table data
   logic                          b0_valid_ff, b0_valid_in;
   logic                          b0_run_ff, b0_run_in;
   logic [1:0]                    b0_quad_ff, b0_quad_in;
   logic signed [SAMPLE_BITS-1:0] b0_i_ff, b0_i_in;
   logic signed [SAMPLE_BITS-1:0] b0_q_ff, b0_q_in;
   logic [SAMPLE_BITS-1:0]        b0_r0_ff, b0_r0_in;
   logic [SAMPLE_BITS-1:0]        b0_r1_ff, b0_r1_in;

   // Stage 1: products
   logic                          b1_valid_ff, b1_valid_in;
   logic                          b1_run_ff, b1_run_in;
   logic signed [SAMPLE_BITS-1:0] b1_i_ff, b1_i_in;
   logic signed [SAMPLE_BITS-1:0] b1_q_ff, b1_q_in;
   logic signed [PROD_BITS-1:0]   b1_ic_ff, b1_ic_in;
   logic signed [PROD_BITS-1:0]   b1_qs_ff, b1_qs_in;
   logic signed [PROD_BITS-1:0]   b1_is_ff, b1_is_in;
   logic signed [PROD_BITS-1:0]   b1_qc_ff, b1_qc_in;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_i_ff, rsp_i_in;
   logic signed [SAMPLE_BITS-1:0] rsp_q_ff, rsp_q_in;

   logic signed [TRIG_BITS-1:0]   sin_v;
   logic signed [TRIG_BITS-1:0]   cos_v;
   logic signed [TRIG_BITS-1:0]   r0_s;
   logic signed [TRIG_BITS-1:0]   r1_s;
   logic signed [ACC_BITS-1:0]    sum_i;
   logic signed [ACC_BITS-1:0]    sum_q;
   logic signed [ACC_BITS-1:0]    rnd_i;
   logic signed [ACC_BITS-1:0]    rnd_q;

   // Pipeline moves whenever the result register is free or being taken
   assign stage_en = ~rsp_valid_ff | ~rsp_stall;
   assign pop      = stage_en & ~queue_empty;

   assign {h_run, h_quad, h_d, h_i, h_q} = queue_head;
   assign addr_lo = {1'b0, h_d};
   assign addr_hi = ROM_ADDR_BITS'(TABLE_SIZE) - addr_lo;

   // Stage 0: two table reads
   always_comb begin
      b0_valid_in = b0_valid_ff;
      b0_run_in   = b0_run_ff;
      b0_quad_in  = b0_quad_ff;
      b0_i_in     = b0_i_ff;
      b0_q_in     = b0_q_ff;
      b0_r0_in    = b0_r0_ff;
      b0_r1_in    = b0_r1_ff;
      if (stage_en) begin
         b0_valid_in = ~queue_empty;
         b0_run_in   = h_run;
         b0_quad_in  = h_quad;
         b0_i_in     = h_i;
         b0_q_in     = h_q;
         b0_r0_in    = rom_tab[addr_lo];
         b0_r1_in    = rom_tab[addr_hi];
      end
   end

   // Sine and cosine from the quadrant
   assign r0_s = $signed({1'b0, b0_r0_ff});
   assign r1_s = $signed({1'b0, b0_r1_ff});

   always_comb begin
      unique case (b0_quad_ff)
         QUAD_FIRST: begin
            sin_v = r0_s;
            cos_v = r1_s;
         end
         QUAD_SECOND: begin
            sin_v = r1_s;
            cos_v = -r0_s;
         end
         QUAD_THIRD: begin
            sin_v = -r0_s;
            cos_v = -r1_s;
         end
         QUAD_FOURTH: begin
            sin_v = -r1_s;
            cos_v = r0_s;
         end
         default: begin
            sin_v = '0;
            cos_v = '0;
         end
      endcase
   end

   // Stage 1: four products
   always_comb begin
      b1_valid_in = b1_valid_ff;
      b1_run_in   = b1_run_ff;
      b1_i_in     = b1_i_ff;
      b1_q_in     = b1_q_ff;
      b1_ic_in    = b1_ic_ff;
      b1_qs_in    = b1_qs_ff;
      b1_is_in    = b1_is_ff;
      b1_qc_in    = b1_qc_ff;
      if (stage_en) begin
         b1_valid_in = b0_valid_ff;
         b1_run_in   = b0_run_ff;
         b1_i_in     = b0_i_ff;
         b1_q_in     = b0_q_ff;
         b1_ic_in    = b0_i_ff * cos_v;
         b1_qs_in    = b0_q_ff * sin_v;
         b1_is_in    = b0_i_ff * sin_v;
         b1_qc_in    = b0_q_ff * cos_v;
      end
   end

   // Sums, round half up, arithmetic shift
   assign sum_i = ACC_BITS'(b1_ic_ff) - ACC_BITS'(b1_qs_ff);
   assign sum_q = ACC_BITS'(b1_is_ff) + ACC_BITS'(b1_qc_ff);
   assign rnd_i = (sum_i + ROUND_BIAS) >>> (SAMPLE_BITS - 1);
   assign rnd_q = (sum_q + ROUND_BIAS) >>> (SAMPLE_BITS - 1);

   // Result register: rotated or passed through
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_i_in     = rsp_i_ff;
      rsp_q_in     = rsp_q_ff;
      if (stage_en) begin
         rsp_valid_in = b1_valid_ff;
         rsp_i_in     = b1_run_ff ? $signed(saturate(rnd_i)) : b1_i_ff;
         rsp_q_in     = b1_run_ff ? $signed(saturate(rnd_q)) : b1_q_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff  <= 1'b0;
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b0_valid_ff  <= b0_valid_in;
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      b0_run_ff  <= b0_run_in;
      b0_quad_ff <= b0_quad_in;
      b0_i_ff    <= b0_i_in;
      b0_q_ff    <= b0_q_in;
      b0_r0_ff   <= b0_r0_in;
      b0_r1_ff   <= b0_r1_in;
      b1_run_ff  <= b1_run_in;
      b1_i_ff    <= b1_i_in;
      b1_q_ff    <= b1_q_in;
      b1_ic_ff   <= b1_ic_in;
      b1_qs_ff   <= b1_qs_in;
      b1_is_ff   <= b1_is_in;
      b1_qc_ff   <= b1_qc_in;
      rsp_i_ff   <= rsp_i_in;
      rsp_q_ff   <= rsp_q_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_i = rsp_i_ff;
   assign rsp_out_q = rsp_q_ff;

endmodule

@@ rtl/complex_frequency_shifter.sv @@
`timescale 1ns / 1ps
// ============================================================================
// complex_frequency_shifter - NCO complex mixer
// Rotates each I/Q sample by a running phase, out = in * exp(j*phase).
// ============================================================================
// One complex sample per clock is taken and one result per clock is given in
// steady state while rsp_stall is low. A sample passes through the four-entry
// queue, the sine table read register of stage 0, the product register of
// stage 1 and the result register, with rounding and saturation in front of
// the result register. The rate of one per clock is set by the dual-port
// table read and the four parallel multipliers, which each take one sample
// per cycle. The phase used is the one held before the sample's own
// increment; clear_phase zeroes it first, also when rotation is off. With
// run_enable low the sample is passed through and the phase holds. Write
// configuration only while no samples are in flight.
// ============================================================================
module complex_frequency_shifter
   import cfs_pkg::*;
#(
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_i,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_q,
   input  logic                          req_clear_phase,
   // rotated output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_i,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_q,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam int ENTRY_BITS = 3 + TABLE_ADDR_BITS + 2 * SAMPLE_BITS;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic                  csr_write;
   logic                  push_valid;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop;
   logic [ENTRY_BITS-1:0] queue_head;
   logic                  queue_full;
   logic                  queue_empty;

   // Register file, always ready
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_RUN_ENABLE: cfg_in.run_enable = csr_data[0];
            REG_PHASE_STEP: cfg_in.phase_step = csr_data[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Intake and phase accumulator
   cfs_front #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_i    (req_sample_i),
      .req_sample_q    (req_sample_q),
      .req_clear_phase (req_clear_phase),
      .queue_full      (queue_full),
      .push_valid      (push_valid),
      .push_data       (push_data)
   );

   // Decoupling queue
   cfs_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .head      (queue_head),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // Rotation datapath
   cfs_back #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_i   (rsp_out_i),
      .rsp_out_q   (rsp_out_q)
   );

endmodule
